@@ design/number_to_ascii_formatter_macros.svh @@
// Assertion macros shared by the number-to-ASCII formatter modules.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef NUMBER_TO_ASCII_FORMATTER_MACROS_SVH
`define NUMBER_TO_ASCII_FORMATTER_MACROS_SVH

// The condition implies the expectation in the same cycle.
`define N2A_ASSERT_SAME(label, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_expr)) \
        else $error(msg);

// The condition implies the expectation in the next cycle.
`define N2A_ASSERT_NEXT(label, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_expr)) \
        else $error(msg);

`endif

@@ design/n2a_pkg.sv @@
// Package for the number-to-ASCII formatter: format codes, widths and
// character helpers. No dependencies.
package n2a_pkg;

    // Format codes carried on req_type.
    localparam int unsigned FMT_W = 2;
    localparam logic [FMT_W-1:0] FMT_HEX32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_HEX64 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_DEC32 = 2'd2;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned NIBBLE_W = 4;

    // Digit counts per format.
    localparam int unsigned HEX32_DIGITS = 8;
    localparam int unsigned HEX64_DIGITS = 16;
    localparam int unsigned DEC_DIGITS   = 10;
    localparam int unsigned HEX_PREFIX_LEN = 2;
    localparam int unsigned DIGIT_CNT_W  = $clog2(HEX64_DIGITS + 1);
    localparam int unsigned PREFIX_CNT_W = $clog2(HEX_PREFIX_LEN + 1);

    // Binary to BCD conversion sizes.
    localparam int unsigned BCD_W     = DEC_DIGITS * NIBBLE_W;
    localparam int unsigned DAB_STEPS = HALF_W;
    localparam int unsigned DAB_CNT_W = $clog2(DAB_STEPS);

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X          = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 8'h57;

    // Status of the BCD conversion unit.
    typedef struct packed {
        logic busy;
        logic done;
    } dab_stat_t;

    // Lowercase ASCII for one hex or BCD digit.
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [NIBBLE_W-1:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
        if (nib < 4'd10)
        begin
            return CH_ZERO + wide;
        end
        return CH_ALPHA_BASE + wide;
    endfunction

endpackage

@@ design/n2a_if.sv @@
// Valid/ready channel interfaces for the number-to-ASCII formatter.
// Depends on n2a_pkg for field widths.
interface n2a_in_if;
    logic                              valid;
    logic                              ready;
    logic [n2a_pkg::FMT_W-1:0]         req_type;
    logic [n2a_pkg::VALUE_W-1:0]       number_value;

    modport source (output valid, req_type, number_value, input ready);
    modport sink   (input valid, req_type, number_value, output ready);
endinterface

interface n2a_out_if;
    logic                              valid;
    logic                              ready;
    logic [n2a_pkg::CHAR_W-1:0]        ascii_char;
    logic                              last_char;

    modport source (output valid, ascii_char, last_char, input ready);
    modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

@@ design/n2a_dabble.sv @@
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on n2a_pkg and number_to_ascii_formatter_macros.svh.
`include "number_to_ascii_formatter_macros.svh"

module n2a_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [n2a_pkg::HALF_W-1:0]    bin,
    output n2a_pkg::dab_stat_t            stat,
    output logic [n2a_pkg::BCD_W-1:0]     bcd
);

    logic [n2a_pkg::HALF_W-1:0]    bin_reg, bin_next;
    logic [n2a_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [n2a_pkg::DAB_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [n2a_pkg::BCD_W-1:0]     adj;
    logic                          last_step;

    assign last_step = (cnt_reg == n2a_pkg::DAB_CNT_W'(n2a_pkg::DAB_STEPS - 1));

    // Add three to every BCD digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < n2a_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*n2a_pkg::NIBBLE_W +: n2a_pkg::NIBBLE_W] >= 4'd5)
            begin
                adj[i*n2a_pkg::NIBBLE_W +: n2a_pkg::NIBBLE_W] =
                    bcd_reg[i*n2a_pkg::NIBBLE_W +: n2a_pkg::NIBBLE_W] + 4'd3;
            end
            else
            begin
                adj[i*n2a_pkg::NIBBLE_W +: n2a_pkg::NIBBLE_W] =
                    bcd_reg[i*n2a_pkg::NIBBLE_W +: n2a_pkg::NIBBLE_W];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[n2a_pkg::BCD_W-2:0], bin_reg[n2a_pkg::HALF_W-1]};
            bin_next = {bin_reg[n2a_pkg::HALF_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg  <= '0;
            bcd_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

    `N2A_ASSERT_SAME(a_start_idle, start, !busy_reg, "conversion started while busy")
    `N2A_ASSERT_NEXT(a_start_runs, start, busy_reg && (cnt_reg == '0), "start did not arm unit")
    `N2A_ASSERT_SAME(a_done_stops, done_reg, !busy_reg, "done raised while still busy")

endmodule

@@ design/number_to_ascii_formatter.sv @@
// Top level of the number-to-ASCII formatter: sequencer, character shifter
// and output register. Depends on n2a_pkg, n2a_if, n2a_dabble and the macros.
//
// Usage:
// The req channel carries one beat per value: req_type selects the format
// (hex of the low 32 bits, hex of all 64 bits, or unsigned decimal of the low
// 32 bits) and number_value the value. The rsp channel returns one ASCII
// character per beat, most significant first, with last_char set on the
// final beat of the run. Hex runs are "0x" plus 8 or 16 lowercase digits;
// decimal runs drop leading zeros and give a single '0' for zero. A
// req_type of 3 is taken and produces no beats.
// One value is worked on at a time; req.ready is high only while idle.
// Unstalled, hex characters go out one per cycle through the output register.
// A decimal value goes through the bit-serial BCD conversion, a hand-off,
// then leading-zero skipping and digit output at one digit position per
// cycle through the shared shifter while the output is not stalled.
// For hex, the accepted beat sets the emit state, which loads the output register.
// When rsp.ready is low the character stays in the output register and the
// sequencer waits. Reset returns the block to idle with the output empty.

`include "number_to_ascii_formatter_macros.svh"

module number_to_ascii_formatter (
    input  logic      clk,
    input  logic      rst_n,
    n2a_in_if.sink    req,
    n2a_out_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    logic [n2a_pkg::VALUE_W-1:0]          data_reg, data_next;
    logic [n2a_pkg::DIGIT_CNT_W-1:0]      digits_reg, digits_next;
    logic [n2a_pkg::PREFIX_CNT_W-1:0]     prefix_reg, prefix_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [n2a_pkg::CHAR_W-1:0]           char_reg, char_next;
    logic                                 last_reg, last_next;

    logic                                 accept;
    logic                                 out_free;
    logic                                 out_load;
    logic                                 dab_start;
    n2a_pkg::dab_stat_t                   dab_stat;
    logic [n2a_pkg::BCD_W-1:0]            dab_bcd;
    logic [n2a_pkg::NIBBLE_W-1:0]         top_nib;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign dab_start = accept && (req.req_type == n2a_pkg::FMT_DEC32);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = (state_reg == ST_EMIT) && out_free;
    assign top_nib   = data_reg[n2a_pkg::VALUE_W-1 -: n2a_pkg::NIBBLE_W];

    // Decimal digits come from the shared shift-and-add-3 unit.
    n2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .bin   (req.number_value[n2a_pkg::HALF_W-1:0]),
        .stat  (dab_stat),
        .bcd   (dab_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        digits_next    = digits_reg;
        prefix_next    = prefix_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        n2a_pkg::FMT_HEX32:
                        begin
                            data_next = {req.number_value[n2a_pkg::HALF_W-1:0],
                                         {n2a_pkg::HALF_W{1'b0}}};
                            digits_next = n2a_pkg::DIGIT_CNT_W'(n2a_pkg::HEX32_DIGITS);
                            prefix_next = n2a_pkg::PREFIX_CNT_W'(n2a_pkg::HEX_PREFIX_LEN);
                            state_next  = ST_EMIT;
                        end
                        n2a_pkg::FMT_HEX64:
                        begin
                            data_next   = req.number_value;
                            digits_next = n2a_pkg::DIGIT_CNT_W'(n2a_pkg::HEX64_DIGITS);
                            prefix_next = n2a_pkg::PREFIX_CNT_W'(n2a_pkg::HEX_PREFIX_LEN);
                            state_next  = ST_EMIT;
                        end
                        n2a_pkg::FMT_DEC32:
                        begin
                            state_next = ST_DABBLE;
                        end
                        default:
                        begin
                            // Unused format code: the beat is dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DABBLE:
            begin
                if (dab_stat.done)
                begin
                    data_next = {dab_bcd, {(n2a_pkg::VALUE_W-n2a_pkg::BCD_W){1'b0}}};
                    digits_next = n2a_pkg::DIGIT_CNT_W'(n2a_pkg::DEC_DIGITS);
                    prefix_next = '0;
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, but always keep the last one.
                if ((top_nib == '0) && (digits_reg != n2a_pkg::DIGIT_CNT_W'(1)))
                begin
                    data_next   = {data_reg[n2a_pkg::VALUE_W-n2a_pkg::NIBBLE_W-1:0],
                                   {n2a_pkg::NIBBLE_W{1'b0}}};
                    digits_next = digits_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next = (prefix_reg == '0) &&
                                (digits_reg == n2a_pkg::DIGIT_CNT_W'(1));
                    if (prefix_reg == n2a_pkg::PREFIX_CNT_W'(n2a_pkg::HEX_PREFIX_LEN))
                    begin
                        char_next   = n2a_pkg::CH_ZERO;
                        prefix_next = prefix_reg - 1'b1;
                    end
                    else if (prefix_reg != '0)
                    begin
                        char_next   = n2a_pkg::CH_X;
                        prefix_next = prefix_reg - 1'b1;
                    end
                    else
                    begin
                        char_next   = n2a_pkg::digit_ascii(top_nib);
                        data_next   = {data_reg[n2a_pkg::VALUE_W-n2a_pkg::NIBBLE_W-1:0],
                                       {n2a_pkg::NIBBLE_W{1'b0}}};
                        digits_next = digits_reg - 1'b1;
                        if (digits_reg == n2a_pkg::DIGIT_CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            data_reg      <= '0;
            digits_reg    <= '0;
            prefix_reg    <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            data_reg      <= data_next;
            digits_reg    <= digits_next;
            prefix_reg    <= prefix_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ascii_char = char_reg;
    assign rsp.last_char  = last_reg;

    `N2A_ASSERT_NEXT(a_last_ends_run, out_load && last_next, state_reg == ST_IDLE, "run did not end after last character")
    `N2A_ASSERT_SAME(a_skip_no_prefix, state_reg == ST_SKIP, prefix_reg == '0, "decimal run carries a hex prefix")
    `N2A_ASSERT_SAME(a_emit_has_digits, state_reg == ST_EMIT, digits_reg != '0, "emitting with no digits left")
    `N2A_ASSERT_NEXT(a_dec_waits, dab_start, state_reg == ST_DABBLE && dab_stat.busy, "decimal request did not start conversion")

endmodule
